[hdl/lgp_pkg.sv]
// ----------------------------------------------------------------------------
// lgp_pkg
// Shared constants, types and helper functions of the linear gradient core.
// ----------------------------------------------------------------------------
package lgp_pkg;

    localparam int NCH        = 3;
    localparam int CH_B       = 0;
    localparam int CH_G       = 1;
    localparam int CH_R       = 2;

    localparam int POS_W      = 12;
    localparam int NZ_W       = 3;
    localparam int CLR_W      = 8;
    localparam int DIM_W      = 13;
    localparam int DEN_W      = DIM_W + 1;
    localparam int NUM_W      = POS_W + 1;
    localparam int PW         = NUM_W + CLR_W;
    localparam int QW         = 10;
    localparam int CW         = DEN_W + QW - 1;
    localparam int DIV_ST     = QW / 2;
    localparam int SUM_W      = CLR_W + 3;
    localparam int MAX_DIM    = 4096;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = NCH * CLR_W;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = NCH * CLR_W;

    localparam logic [CFG_IDX_W-1:0] REG_START = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HGT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIR   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NOISE = 3'd5;

    localparam logic [1:0] DIR_VERT = 2'd0;
    localparam logic [1:0] DIR_HORZ = 2'd1;
    localparam logic [1:0] DIR_DIAG = 2'd2;
    localparam logic [1:0] DIR_FLAT = 2'd3;

    typedef struct packed {
        logic [NCH-1:0][CLR_W-1:0] start_clr;
        logic [NCH-1:0][CLR_W-1:0] end_clr;
        logic [DIM_W-1:0]          width;
        logic [DIM_W-1:0]          height;
        logic [1:0]                dir;
        logic                      noise_en;
    } cfg_t;

    typedef struct packed {
        logic [NCH-1:0][NZ_W-1:0] noise;
        logic [POS_W-1:0]         pos_y;
        logic [POS_W-1:0]         pos_x;
    } pix_t;

    typedef struct packed {
        logic [NUM_W-1:0]          num;
        logic [DEN_W-1:0]          den;
        logic [NCH-1:0][CLR_W-1:0] mag;
        logic [NCH-1:0]            neg;
        logic [NCH-1:0][NZ_W-1:0]  noise;
    } term_t;

    typedef struct packed {
        logic [NCH-1:0][PW-1:0]   rem;
        logic [NCH-1:0][QW-1:0]   quo;
        logic [NCH-1:0]           neg;
        logic [DEN_W-1:0]         den;
        logic [NCH-1:0][NZ_W-1:0] noise;
    } quo_t;

    function automatic logic [DEN_W-1:0] sat_dim(input logic [DIM_W-1:0] d);
        logic [DEN_W-1:0] r;
        if (d == '0)
            r = DEN_W'(1);
        else if (d > DIM_W'(MAX_DIM))
            r = DEN_W'(MAX_DIM);
        else
            r = DEN_W'(d);
        return r;
    endfunction

    // one restoring step: bit PW is the quotient bit, the rest the new remainder
    function automatic logic [PW:0] div_step(input logic [PW-1:0] rem,
                                             input logic [CW-1:0] dsh);
        logic [CW-1:0] r;
        logic [PW:0]   res;
        r = CW'(rem);
        if (r >= dsh)
            res = {1'b1, PW'(r - dsh)};
        else
            res = {1'b0, rem};
        return res;
    endfunction

endpackage

[hdl/lgp_cfg.sv]
// ----------------------------------------------------------------------------
// lgp_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module lgp_cfg
    import lgp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_START: cfg_next.start_clr = cfg_data;
                REG_END:   cfg_next.end_clr   = cfg_data;
                REG_WIDTH: cfg_next.width     = cfg_data[DIM_W-1:0];
                REG_HGT:   cfg_next.height    = cfg_data[DIM_W-1:0];
                REG_DIR:   cfg_next.dir       = cfg_data[1:0];
                REG_NOISE: cfg_next.noise_en  = cfg_data[0];
                default:   cfg_next           = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_clr <= '0;
            cfg_reg.end_clr   <= '0;
            cfg_reg.width     <= DIM_W'(1);
            cfg_reg.height    <= DIM_W'(1);
            cfg_reg.dir       <= DIR_VERT;
            cfg_reg.noise_en  <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[hdl/lgp_ramp.sv]
// ----------------------------------------------------------------------------
// lgp_ramp
// Ramp term stages: select numerator, denominator and channel deltas, then
// form the product magnitudes.
// ----------------------------------------------------------------------------
module lgp_ramp
    import lgp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic in_valid,
    output logic in_ready,
    input  pix_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output quo_t out_data
);

    logic  t_vld_reg;
    term_t t_reg;
    term_t t_next;
    logic  p_vld_reg;
    quo_t  p_reg;
    quo_t  p_next;
    logic  t_rdy;
    logic  p_rdy;

    always_comb
    begin
        logic [DEN_W-1:0] w;
        logic [DEN_W-1:0] h;
        logic [CLR_W:0]   d;
        w = sat_dim(cfg.width);
        h = sat_dim(cfg.height);
        t_next.noise = in_data.noise;
        unique case (cfg.dir)
            DIR_VERT:
            begin
                t_next.num = NUM_W'(in_data.pos_y);
                t_next.den = h;
            end
            DIR_HORZ:
            begin
                t_next.num = NUM_W'(in_data.pos_x);
                t_next.den = w;
            end
            DIR_DIAG:
            begin
                t_next.num = NUM_W'(in_data.pos_x) + NUM_W'(in_data.pos_y);
                t_next.den = w + h;
            end
            default:
            begin
                t_next.num = '0;
                t_next.den = DEN_W'(1);
            end
        endcase
        for (int c = 0; c < NCH; c++)
        begin
            d = {1'b0, cfg.end_clr[c]} - {1'b0, cfg.start_clr[c]};
            t_next.neg[c] = d[CLR_W];
            t_next.mag[c] = d[CLR_W] ? CLR_W'(-d) : d[CLR_W-1:0];
        end
    end

    always_comb
    begin
        p_next.neg   = t_reg.neg;
        p_next.den   = t_reg.den;
        p_next.noise = t_reg.noise;
        for (int c = 0; c < NCH; c++)
        begin
            p_next.rem[c] = PW'(t_reg.num) * PW'(t_reg.mag[c]);
            p_next.quo[c] = '0;
        end
    end

    assign p_rdy    = !p_vld_reg || out_ready;
    assign t_rdy    = !t_vld_reg || p_rdy;
    assign in_ready = t_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_vld_reg <= 1'b0;
            p_vld_reg <= 1'b0;
        end
        else
        begin
            if (t_rdy)
                t_vld_reg <= in_valid;
            if (p_rdy)
                p_vld_reg <= t_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (t_rdy && in_valid)
            t_reg <= t_next;
        if (p_rdy && t_vld_reg)
            p_reg <= p_next;
    end

    assign out_valid = p_vld_reg;
    assign out_data  = p_reg;

endmodule

[hdl/lgp_div.sv]
// ----------------------------------------------------------------------------
// lgp_div
// Restoring divider pipeline, two quotient bits per stage for all channels.
// The top quotient bit flags a quotient too large to matter after clamping.
// ----------------------------------------------------------------------------
module lgp_div
    import lgp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  quo_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output quo_t out_data
);

    logic            vld_reg  [DIV_ST];
    quo_t            stg_reg  [DIV_ST];
    quo_t            stg_next [DIV_ST];
    quo_t            src      [DIV_ST];
    logic            src_vld  [DIV_ST];
    logic [DIV_ST:0] rdy;

    always_comb
    begin
        rdy[DIV_ST] = out_ready;
        for (int k = DIV_ST - 1; k >= 0; k--)
            rdy[k] = !vld_reg[k] || rdy[k+1];
    end

    genvar k;
    generate
        for (k = 0; k < DIV_ST; k++)
        begin : g_stage
            localparam int HI = QW - 1 - 2 * k;

            if (k == 0)
            begin : g_head
                assign src[k]     = in_data;
                assign src_vld[k] = in_valid;
            end
            else
            begin : g_body
                assign src[k]     = stg_reg[k-1];
                assign src_vld[k] = vld_reg[k-1];
            end

            always_comb
            begin
                logic [PW:0] s1;
                logic [PW:0] s2;
                stg_next[k] = src[k];
                for (int c = 0; c < NCH; c++)
                begin
                    s1 = div_step(src[k].rem[c], CW'(src[k].den) << HI);
                    s2 = div_step(s1[PW-1:0], CW'(src[k].den) << (HI - 1));
                    stg_next[k].rem[c]        = s2[PW-1:0];
                    stg_next[k].quo[c][HI]    = s1[PW];
                    stg_next[k].quo[c][HI-1]  = s2[PW];
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[k] <= 1'b0;
                else if (rdy[k])
                    vld_reg[k] <= src_vld[k];
            end

            always_ff @(posedge clk)
            begin
                if (rdy[k] && src_vld[k])
                    stg_reg[k] <= stg_next[k];
            end
        end
    endgenerate

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[DIV_ST-1];
    assign out_data  = stg_reg[DIV_ST-1];

endmodule

[hdl/lgp_mix.sv]
// ----------------------------------------------------------------------------
// lgp_mix
// Output stage: apply sign, add start color and dither, clamp to 0..255.
// ----------------------------------------------------------------------------
module lgp_mix
    import lgp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cfg_t                  cfg,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  quo_t                  in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [OUT_DATA_W-1:0] out_data
);

    logic                      vld_reg;
    logic [NCH-1:0][CLR_W-1:0] px_reg;
    logic [NCH-1:0][CLR_W-1:0] px_next;

    always_comb
    begin
        logic [QW-2:0]           qs;
        logic signed [SUM_W-1:0] term;
        logic signed [SUM_W-1:0] nz;
        logic signed [SUM_W-1:0] v;
        for (int c = 0; c < NCH; c++)
        begin
            qs   = in_data.quo[c][QW-1] ? '1 : in_data.quo[c][QW-2:0];
            term = in_data.neg[c] ? -SUM_W'(qs) : SUM_W'(qs);
            nz   = cfg.noise_en ? SUM_W'(signed'(in_data.noise[c])) : '0;
            v    = SUM_W'(cfg.start_clr[c]) + term + nz;
            if (v < 0)
                px_next[c] = '0;
            else if (v > SUM_W'(255))
                px_next[c] = '1;
            else
                px_next[c] = v[CLR_W-1:0];
        end
    end

    assign in_ready = !vld_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (in_ready)
            vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            px_reg <= px_next;
    end

    assign out_valid = vld_reg;
    assign out_data  = {px_reg[CH_B], px_reg[CH_G], px_reg[CH_R]};

endmodule

[hdl/linear_gradient_pixel_core.sv]
// ----------------------------------------------------------------------------
// linear_gradient_pixel_core
// Linear color gradient pixel generator: one RGB beat out per position beat.
//
//   channel   dir  width  content
//   s_axis    in   40     pos_x, pos_y, noise red, green, blue
//   m_axis    out  24     red, green, blue
//   cfg       in   3+24   register index and write data
//
// One beat per cycle sustained while m_axis accepts; the pipeline stages are:
// ramp select, multiply, five divider stages (two quotient bits each), mix.
// Reset clears all stage valid bits and loads the register defaults.
// A stall on m_axis holds each full stage; empty stages keep filling.
// ----------------------------------------------------------------------------
module linear_gradient_pixel_core
    import lgp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // pos_x, pos_y, noise_red, noise_green, noise_blue
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // out_red, out_green, out_blue
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg;
    pix_t pix;
    logic rp_valid;
    logic rp_ready;
    quo_t rp_data;
    logic dv_valid;
    logic dv_ready;
    quo_t dv_data;

    assign pix.pos_x       = s_tdata[11:0];
    assign pix.pos_y       = s_tdata[23:12];
    assign pix.noise[CH_R] = s_tdata[26:24];
    assign pix.noise[CH_G] = s_tdata[29:27];
    assign pix.noise[CH_B] = s_tdata[32:30];

    lgp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lgp_ramp u_ramp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (pix),
        .out_valid (rp_valid),
        .out_ready (rp_ready),
        .out_data  (rp_data)
    );

    lgp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rp_valid),
        .in_ready  (rp_ready),
        .in_data   (rp_data),
        .out_valid (dv_valid),
        .out_ready (dv_ready),
        .out_data  (dv_data)
    );

    lgp_mix u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (dv_valid),
        .in_ready  (dv_ready),
        .in_data   (dv_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output stage empty");

    a_div_remainder: assert property (@(posedge clk) disable iff (!rst_n)
        dv_valid |->
            (dv_data.quo[CH_R][QW-1] || (dv_data.rem[CH_R] < PW'(dv_data.den))) &&
            (dv_data.quo[CH_G][QW-1] || (dv_data.rem[CH_G] < PW'(dv_data.den))) &&
            (dv_data.quo[CH_B][QW-1] || (dv_data.rem[CH_B] < PW'(dv_data.den))))
        else $error("divider remainder not below divisor");

endmodule
